/* sv/mtrp_pkg.sv */
// Package: types and constants shared by the Modbus TCP response parser.
`timescale 1ns / 1ps
package mtrp_pkg;

	localparam logic [15:0] TRANSACTION_ID_RESET = 16'hB16E;

	localparam int DATA_SLOTS = 4;
	localparam int DATA_IDX_W = $clog2(DATA_SLOTS);

	localparam logic [7:0] FC_READ_COILS      = 8'h01;
	localparam logic [7:0] FC_READ_DISCRETE   = 8'h02;
	localparam logic [7:0] FC_READ_HOLDING    = 8'h03;
	localparam logic [7:0] FC_READ_INPUT_REGS = 8'h04;
	localparam logic [7:0] FC_WRITE_COIL      = 8'h05;
	localparam logic [7:0] FC_WRITE_REG       = 8'h06;
	localparam logic [7:0] FC_WRITE_COILS     = 8'h0F;
	localparam logic [7:0] FC_WRITE_REGS      = 8'h10;

	localparam logic [7:0] FIXED_DATA_BYTES = 8'd4;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HEADER = 3'd1,
		PH_LENGTH = 3'd2,
		PH_UNIT   = 3'd3,
		PH_FUNC   = 3'd4,
		PH_COUNT  = 3'd5,
		PH_DATA   = 3'd6
	} phase_t;

	typedef struct packed {
		logic        frame_done;
		logic        frame_dropped;
		logic [7:0]  function_code;
		logic [7:0]  unit_id;
		logic [15:0] length_value;
		logic [31:0] inputs_image;
		logic [15:0] message_count;
	} result_t;

endpackage

/* sv/mtrp_parser.sv */
// Parser state and per-byte next-state logic for Modbus TCP response frames.
`timescale 1ns / 1ps
module mtrp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	input  logic [15:0]       expected_id,
	output mtrp_pkg::result_t res
);
	import mtrp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  func_q, func_d;
	logic [7:0]  unit_q, unit_d;
	logic [15:0] len_q, len_d;
	logic [7:0]  exp_q, exp_d;
	logic [7:0]  data_q [DATA_SLOTS];
	logic [7:0]  data_d [DATA_SLOTS];
	logic [31:0] word_q, word_d;
	logic [15:0] frames_q, frames_d;
	logic        done, dropped;

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		func_d   = func_q;
		unit_d   = unit_q;
		len_d    = len_q;
		exp_d    = exp_q;
		data_d   = data_q;
		word_d   = word_q;
		frames_d = frames_q;
		done     = 1'b0;
		dropped  = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				if (cnt_q == 8'd1 && rx_byte == expected_id[7:0]) begin
					cnt_d = 8'd2;
				end else if (cnt_q == 8'd2 && rx_byte == 8'd0) begin
					cnt_d = 8'd3;
				end else if (cnt_q == 8'd3 && rx_byte == 8'd0) begin
					phase_d = PH_LENGTH;
					cnt_d   = 8'd0;
				end else begin
					phase_d = PH_IDLE;
					dropped = 1'b1;
				end
			end
			PH_LENGTH: begin
				if (cnt_q == 8'd0) begin
					len_d = {rx_byte, 8'h00};
					cnt_d = 8'd1;
				end else begin
					len_d   = len_q | {8'h00, rx_byte};
					phase_d = PH_UNIT;
				end
			end
			PH_UNIT: begin
				unit_d  = rx_byte;
				phase_d = PH_FUNC;
			end
			PH_FUNC: begin
				func_d = rx_byte;
				cnt_d  = 8'd0;
				for (int i = 0; i < DATA_SLOTS; i++) data_d[i] = 8'h00;
				if (rx_byte inside {[FC_READ_COILS:FC_READ_INPUT_REGS]}) begin
					phase_d = PH_COUNT;
				end else if (rx_byte inside {FC_WRITE_COIL, FC_WRITE_REG,
						FC_WRITE_COILS, FC_WRITE_REGS}) begin
					exp_d   = FIXED_DATA_BYTES;
					phase_d = PH_DATA;
				end else begin
					phase_d = PH_IDLE;
					dropped = 1'b1;
				end
			end
			PH_COUNT: begin
				exp_d   = rx_byte;
				cnt_d   = 8'd0;
				phase_d = PH_DATA;
			end
			PH_DATA: begin
				if (cnt_q < 8'(DATA_SLOTS)) data_d[cnt_q[DATA_IDX_W-1:0]] = rx_byte;
				if ({1'b0, cnt_q} + 9'd1 >= {1'b0, exp_q}) begin
					if (func_q == FC_READ_DISCRETE)
						word_d = {data_d[3], data_d[2], data_d[1], data_d[0]};
					frames_d = frames_q + 16'd1;
					phase_d  = PH_IDLE;
					done     = 1'b1;
				end
				cnt_d = cnt_q + 8'd1;
			end
			default: begin
				if (rx_byte == expected_id[15:8]) begin
					phase_d = PH_HEADER;
					cnt_d   = 8'd1;
				end else begin
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			func_q   <= '0;
			unit_q   <= '0;
			len_q    <= '0;
			exp_q    <= '0;
			word_q   <= '0;
			frames_q <= '0;
			for (int i = 0; i < DATA_SLOTS; i++) data_q[i] <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			func_q   <= func_d;
			unit_q   <= unit_d;
			len_q    <= len_d;
			exp_q    <= exp_d;
			word_q   <= word_d;
			frames_q <= frames_d;
			data_q   <= data_d;
		end
	end

	assign res.frame_done    = done;
	assign res.frame_dropped = dropped;
	assign res.function_code = func_d;
	assign res.unit_id       = unit_d;
	assign res.length_value  = len_d;
	assign res.inputs_image  = word_d;
	assign res.message_count = frames_d;

`ifndef SYNTHESIS
	a_count_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && done |=> frames_q == $past(frames_q) + 16'd1)
		else $error("frame count did not advance on a completed frame");
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(step && done) |=> $stable(frames_q))
		else $error("frame count moved without a completed frame");
	a_drop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && dropped |=> phase_q == PH_IDLE)
		else $error("dropped frame did not return to idle");
	a_done_not_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!(done && dropped))
		else $error("frame both completed and dropped");
`endif

endmodule

/* sv/modbus_tcp_response_parser.sv */
// Top level: Modbus TCP response parser with config register and result register.
//
//  channel   signals                       width  dir
//  in        in_valid in_ready rx_byte     8      byte stream in
//  out       out_valid out_ready + fields  82     one result per byte
//  cfg       cfg_valid cfg_ready cfg_data  16     transaction id write
//
//  One byte per clock while the output is not stalled; the parser state updates on
//  the transfer and the result lands in the output register in the same edge.
//  in_ready is high while the output register is empty or being drained.
//  A stalled output holds one result; input then waits until it is taken.
//  Reset clears parser state, the result flag and sets the id to 0xB16E.
`timescale 1ns / 1ps
module modbus_tcp_response_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_done,
	output logic        frame_dropped,
	output logic [7:0]  function_code,
	output logic [7:0]  unit_id,
	output logic [15:0] length_value,
	output logic [31:0] inputs_image,
	output logic [15:0] message_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import mtrp_pkg::*;

	logic [15:0] tid_q;
	logic        out_valid_q;
	result_t     res;
	result_t     res_q;
	logic        step;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign step      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tid_q <= TRANSACTION_ID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tid_q <= cfg_data;
		end
	end

	mtrp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte    (rx_byte),
		.expected_id(tid_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) res_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign frame_done    = res_q.frame_done;
	assign frame_dropped = res_q.frame_dropped;
	assign function_code = res_q.function_code;
	assign unit_id       = res_q.unit_id;
	assign length_value  = res_q.length_value;
	assign inputs_image  = res_q.inputs_image;
	assign message_count = res_q.message_count;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(res_q))
		else $error("pending result lost or changed while stalled");
	a_load_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("accepted byte produced no result");
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.frame_done && res_q.frame_dropped))
		else $error("result flagged both done and dropped");
`endif

endmodule
